// ----- hdl/qph_pkg.sv -----
// Shared types and constants of the quadratic probe hash set.
package qph_pkg;

   localparam int SLOTS_DEFAULT     = 1024;
   localparam int KEY_WIDTH_DEFAULT = 31;
   localparam int MOD_WIDTH         = 11;
   localparam logic [MOD_WIDTH-1:0] MOD_RESET = 11'd1021;

   localparam logic [1:0] ST_PRESENT  = 2'd0;
   localparam logic [1:0] ST_ABSENT   = 2'd1;
   localparam logic [1:0] ST_INSERTED = 2'd2;
   localparam logic [1:0] ST_FULL     = 2'd3;

   // controller to datapath
   typedef struct packed {
      logic load;       // capture request word, start remainder
      logic div_step;   // one remainder bit
      logic probe_init; // set probe position to home
      logic rd;         // read slot at probe position
      logic advance;    // move to next probe
      logic wr;         // store key at probe position
      logic clr_step;   // clear one valid bit
      logic fin;        // latch response
      logic [1:0] status;
   } qph_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic div_done;
      logic slot_valid;
      logic key_match;
      logic probe_last;
      logic clr_done;
      logic mode;
   } qph_sts_type;

endpackage

// ----- hdl/qph_datapath.sv -----
// Datapath: key remainder, probe walk, slot memories, counters and response register.
module qph_datapath #(
   parameter int SLOTS     = qph_pkg::SLOTS_DEFAULT,
   parameter int KEY_WIDTH = qph_pkg::KEY_WIDTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  qph_pkg::qph_cmd_type           cmd,
   output qph_pkg::qph_sts_type           sts,
   input  logic [qph_pkg::MOD_WIDTH-1:0]  modulus,
   input  logic                           req_mode,
   input  logic [KEY_WIDTH-1:0]           req_key,
   output logic [1:0]                     rsp_status,
   output logic [$clog2(SLOTS)-1:0]       rsp_slot_index,
   output logic [$clog2(SLOTS+1)-1:0]     rsp_entry_total,
   output logic                           rsp_half_full
);
   localparam int AW  = $clog2(SLOTS);
   localparam int CW  = $clog2(SLOTS+1);
   localparam int MW  = qph_pkg::MOD_WIDTH;
   localparam int RW  = (CW > MW ? CW : MW) + 1;
   localparam int KCW = $clog2(KEY_WIDTH+1);

   logic [RW-1:0] m_eff;
   always_comb begin
      if (modulus == '0) m_eff = RW'(1);
      else if (RW'(modulus) > RW'(SLOTS)) m_eff = RW'(SLOTS);
      else m_eff = RW'(modulus);
   end

   logic [KEY_WIDTH-1:0] key_ff, key_in, shk_ff, shk_in;
   logic                 mode_ff;
   logic [RW-1:0]        m_ff, rem_ff, rem_in, pos_ff, pos_in, inc_ff, inc_in, idx_ff, idx_in;
   logic [KCW-1:0]       bit_ff, bit_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [AW-1:0]        clr_ff;
   logic [AW:0]          clr_full;

   logic [RW:0] rem_sh, rem_sub;
   always_comb begin
      rem_sh  = {rem_ff, shk_ff[KEY_WIDTH-1]};
      rem_sub = rem_sh - {1'b0, m_ff};
   end

   logic [RW:0] pos_sum, pos_wrap;
   always_comb begin
      pos_sum  = {1'b0, pos_ff} + {1'b0, inc_ff};
      pos_wrap = pos_sum - {1'b0, m_ff};
   end

   logic [RW:0] inc_sum, inc_wrap;
   always_comb begin
      inc_sum  = {1'b0, inc_ff} + (RW+1)'(2);
      inc_wrap = inc_sum - {1'b0, m_ff};
   end

   always_comb begin
      key_in = key_ff;
      shk_in = shk_ff;
      rem_in = rem_ff;
      bit_in = bit_ff;
      pos_in = pos_ff;
      inc_in = inc_ff;
      idx_in = idx_ff;
      if (cmd.load) begin
         key_in = req_key;
         shk_in = req_key;
         rem_in = '0;
         bit_in = KCW'(KEY_WIDTH);
      end
      if (cmd.div_step) begin
         shk_in = shk_ff << 1;
         rem_in = rem_sub[RW] ? rem_sh[RW-1:0] : rem_sub[RW-1:0];
         bit_in = bit_ff - KCW'(1);
      end
      if (cmd.probe_init) begin
         pos_in = rem_ff;
         inc_in = (m_ff == RW'(1)) ? RW'(0) : RW'(1);
         idx_in = '0;
      end
      if (cmd.advance) begin
         // (i+1)^2 - i^2 = 2i+1, kept reduced modulo m
         pos_in = pos_wrap[RW] ? pos_sum[RW-1:0] : pos_wrap[RW-1:0];
         inc_in = inc_wrap[RW] ? inc_sum[RW-1:0] : inc_wrap[RW-1:0];
         if (!inc_wrap[RW]) begin
            inc_in = (inc_wrap[RW-1:0] >= m_ff) ? inc_wrap[RW-1:0] - m_ff : inc_wrap[RW-1:0];
         end
         idx_in = idx_ff + RW'(1);
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      shk_ff <= shk_in;
      rem_ff <= rem_in;
      bit_ff <= bit_in;
      pos_ff <= pos_in;
      inc_ff <= inc_in;
      idx_ff <= idx_in;
      if (cmd.load) begin
         mode_ff <= req_mode;
         m_ff    <= m_eff;
      end
   end

   // slot memories
   logic [KEY_WIDTH-1:0] key_mem [SLOTS];
   logic                 val_mem [SLOTS];
   logic [KEY_WIDTH-1:0] rd_key_ff;
   logic                 rd_val_ff;
   logic [AW-1:0]        addr;
   assign addr = pos_ff[AW-1:0];

   always_ff @(posedge clock) begin
      if (cmd.wr) key_mem[addr] <= key_ff;
      if (cmd.rd) rd_key_ff <= key_mem[addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.clr_step) val_mem[clr_ff] <= 1'b0;
      else if (cmd.wr) val_mem[addr] <= 1'b1;
      if (cmd.rd) rd_val_ff <= val_mem[addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (cmd.clr_step) clr_ff <= clr_ff + AW'(1);
         if (cmd.wr && cnt_ff < CW'(SLOTS)) cnt_ff <= cnt_ff + CW'(1);
      end
   end
   assign clr_full = {1'b0, clr_ff} + (AW+1)'(1);

   always_comb begin
      sts.div_done   = (bit_ff == '0);
      sts.slot_valid = rd_val_ff;
      sts.key_match  = (rd_key_ff == key_ff);
      sts.probe_last = (idx_ff + RW'(1) >= m_ff);
      sts.clr_done   = clr_full[AW];
      sts.mode       = mode_ff;
   end

   // response register; the count includes this item's insert
   logic [CW-1:0] cnt_next;
   assign cnt_next = (cmd.wr && cnt_ff < CW'(SLOTS)) ? cnt_ff + CW'(1) : cnt_ff;
   always_ff @(posedge clock) begin
      if (cmd.fin) begin
         rsp_status      <= cmd.status;
         rsp_slot_index  <= (cmd.status == qph_pkg::ST_FULL) ? '0 : addr;
         rsp_entry_total <= cnt_next;
         rsp_half_full   <= (RW'(cnt_next) >= (m_ff >> 1));
      end
   end
endmodule

// ----- hdl/qph_ctrl.sv -----
// Controller: sequences clearing, remainder, probe walk and response handshake.
module qph_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output qph_pkg::qph_cmd_type cmd,
   input  qph_pkg::qph_sts_type sts
);
   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_DIV   = 3'd2;
   localparam logic [2:0] S_READ  = 3'd3;
   localparam logic [2:0] S_CHECK = 3'd4;
   localparam logic [2:0] S_HOLD  = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       rv_ff, rv_in;
   logic       take;

   assign req_stall = !(state_ff == S_IDLE && (!rv_ff || !rsp_stall));
   assign take      = req_valid && !req_stall;
   assign rsp_valid = rv_ff;

   always_comb begin
      state_in = state_ff;
      rv_in    = rv_ff;
      cmd      = '0;
      if (rv_ff && !rsp_stall) rv_in = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (take) begin
               cmd.load = 1'b1;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (sts.div_done) begin
               cmd.probe_init = 1'b1;
               state_in = S_READ;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         S_READ: begin
            cmd.rd = 1'b1;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (!sts.slot_valid || sts.key_match) begin
               if (!sts.slot_valid) begin
                  cmd.status = sts.mode ? qph_pkg::ST_INSERTED : qph_pkg::ST_ABSENT;
                  cmd.wr     = sts.mode;
               end else begin
                  cmd.status = qph_pkg::ST_PRESENT;
               end
               state_in = S_HOLD;
            end else if (sts.probe_last) begin
               cmd.status = qph_pkg::ST_FULL;
               state_in = S_HOLD;
            end else begin
               cmd.advance = 1'b1;
               state_in = S_READ;
            end
            if (state_in == S_HOLD) cmd.fin = !rv_in;
            if (state_in == S_HOLD && !rv_in) begin
               rv_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_HOLD: begin
            // previous word still waits; stay here until it is taken
            if (!rv_ff || !rsp_stall) begin
               rv_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         rv_ff    <= rv_in;
      end
   end
endmodule

// ----- hdl/quadratic_probe_hash_set.sv -----
// Quadratic probe hash set: top level with modulus register, controller and datapath.
// Flow: a request is accepted, its key remainder is formed bit-serially, then each
// probe reads a slot and checks it. A new item is taken only once the last one is
// through; the bit-serial remainder unit and the single-port slot memory walk serve one item at a time.
// Reset: synchronous; a clearing pass empties the valid marks, with no item accepted
// meanwhile. The modulus resets to 1021.
module quadratic_probe_hash_set #(
   parameter int SLOTS     = qph_pkg::SLOTS_DEFAULT,
   parameter int KEY_WIDTH = qph_pkg::KEY_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_mode,
   input  logic [KEY_WIDTH-1:0]          req_key,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_status,
   output logic [$clog2(SLOTS)-1:0]      rsp_slot_index,
   output logic [$clog2(SLOTS+1)-1:0]    rsp_entry_total,
   output logic                          rsp_half_full,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [qph_pkg::MOD_WIDTH-1:0] csr_table_modulus
);
   logic [qph_pkg::MOD_WIDTH-1:0] mod_ff;
   qph_pkg::qph_cmd_type cmd;
   qph_pkg::qph_sts_type sts;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) mod_ff <= qph_pkg::MOD_RESET;
      else if (csr_valid) mod_ff <= csr_table_modulus;
   end

   qph_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
      .cmd, .sts
   );

   qph_datapath #(.SLOTS(SLOTS), .KEY_WIDTH(KEY_WIDTH)) u_dp (
      .clock, .reset, .cmd, .sts, .modulus(mod_ff), .req_mode, .req_key,
      .rsp_status, .rsp_slot_index, .rsp_entry_total, .rsp_half_full
   );
endmodule

// ----- sim/tb_quadratic_probe_hash_set.sv -----
// Self-checking testbench for the quadratic probe hash set.
`timescale 1ns / 100ps

module tb_quadratic_probe_hash_set;

   localparam int SLOTS = 1024;
   localparam int KW    = 31;
   localparam int CYCLE_LIMIT = 6000000;

   typedef struct packed {
      logic [1:0]  status;
      logic [9:0]  slot_index;
      logic [10:0] entry_total;
      logic        half_full;
   } hash_result_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic              req_mode = 1'b0;
   logic [KW-1:0]     req_key = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [1:0]        rsp_status;
   logic [9:0]        rsp_slot_index;
   logic [10:0]       rsp_entry_total;
   logic              rsp_half_full;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [qph_pkg::MOD_WIDTH-1:0] csr_table_modulus = '0;

   quadratic_probe_hash_set dut (
      .clock, .reset, .req_valid, .req_stall, .req_mode, .req_key,
      .rsp_valid, .rsp_stall, .rsp_status, .rsp_slot_index, .rsp_entry_total,
      .rsp_half_full, .csr_valid, .csr_ready, .csr_table_modulus
   );

   always #5 clock = ~clock;

   // shadow table
   logic [qph_pkg::MOD_WIDTH-1:0] shadow_modulus;
   logic                 shadow_used [SLOTS];
   logic [KW-1:0]        shadow_key [SLOTS];
   int unsigned          shadow_count;

   hash_result_type expected_results [$];
   int  error_count = 0;
   int  result_count = 0;
   int  item_count = 0;
   int  cycle_count = 0;
   bit  sender_gaps = 1'b1;
   bit  receiver_gaps = 1'b1;
   int  hold_off = 0;
   logic [KW-1:0] key_pool [$];

   function automatic hash_result_type probe_table(input logic mode, input logic [KW-1:0] key);
      hash_result_type r;
      int unsigned m;
      longint unsigned home, pos;
      m = shadow_modulus;
      if (m == 0) m = 1;
      if (m > SLOTS) m = SLOTS;
      home = key % m;
      r.status = qph_pkg::ST_FULL;
      r.slot_index = '0;
      for (int unsigned i = 0; i < m; i++) begin
         pos = (home + longint'(i) * i) % m;
         if (!shadow_used[pos]) begin
            r.slot_index = pos[9:0];
            if (mode) begin
               shadow_used[pos] = 1'b1;
               shadow_key[pos] = key;
               if (shadow_count < SLOTS) shadow_count++;
               r.status = qph_pkg::ST_INSERTED;
            end else begin
               r.status = qph_pkg::ST_ABSENT;
            end
            break;
         end
         if (shadow_key[pos] == key) begin
            r.slot_index = pos[9:0];
            r.status = qph_pkg::ST_PRESENT;
            break;
         end
      end
      r.entry_total = shadow_count[10:0];
      r.half_full = (shadow_count >= m / 2);
      return r;
   endfunction

   // valid stays up between back-to-back words; drop it only for a gap or a drain
   task automatic send_word(input logic mode, input logic [KW-1:0] key);
      if (sender_gaps && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode  <= mode;
      req_key   <= key;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_results.push_back(probe_table(mode, key));
      if (mode) key_pool.push_back(key);
      item_count++;
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_modulus(input logic [qph_pkg::MOD_WIDTH-1:0] value);
      drain();
      csr_valid <= 1'b1;
      csr_table_modulus <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      shadow_modulus = value;
   endtask

   function automatic logic [KW-1:0] pick_key();
      if (key_pool.size() != 0 && $urandom_range(0, 2) == 0)
         return key_pool[$urandom_range(0, key_pool.size() - 1)];
      case ($urandom_range(0, 3))
         0: return KW'($urandom_range(0, 4000));
         1: return {KW{1'b1}} - KW'($urandom_range(0, 50));
         default: return KW'($urandom);
      endcase
   endfunction

   // receiver stall and result checking
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[quadratic_probe_hash_set] ERROR");
         $finish;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         hash_result_type want;
         result_count++;
         if (expected_results.size() == 0) begin
            $error("unexpected result word");
            error_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_status !== want.status) begin
               $error("status exp %0d got %0d", want.status, rsp_status);
               error_count++;
            end
            if (rsp_slot_index !== want.slot_index) begin
               $error("slot_index exp %0d got %0d", want.slot_index, rsp_slot_index);
               error_count++;
            end
            if (rsp_entry_total !== want.entry_total) begin
               $error("entry_total exp %0d got %0d", want.entry_total, rsp_entry_total);
               error_count++;
            end
            if (rsp_half_full !== want.half_full) begin
               $error("half_full exp %0d got %0d", want.half_full, rsp_half_full);
               error_count++;
            end
         end
      end
      if (hold_off > 0) begin
         hold_off--;
         rsp_stall <= 1'b1;
      end else if (receiver_gaps && !rsp_stall && $urandom_range(0, 7) == 0) begin
         hold_off = $urandom_range(0, 15);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic test_directed;
      send_word(1'b0, '0);
      send_word(1'b1, '0);
      send_word(1'b1, '0);
      send_word(1'b1, {KW{1'b1}});
      send_word(1'b0, {KW{1'b1}});
      send_word(1'b1, KW'(1021));
      send_word(1'b1, KW'(2042));
      send_word(1'b1, KW'(3063));
      send_word(1'b0, KW'(4084));
      send_word(1'b0, KW'(2042));
      send_word(1'b1, KW'(31'h2AAAAAAA));
      send_word(1'b1, KW'(31'h55555555));
   endtask

   // tiny modulus: fill it up and hit the probe limit
   task automatic test_probe_limit(input logic [qph_pkg::MOD_WIDTH-1:0] m, input int n);
      write_modulus(m);
      for (int i = 0; i < n; i++) send_word(1'b1, KW'($urandom));
      send_word(1'b0, KW'($urandom));
   endtask

   task automatic test_modulus_extremes;
      write_modulus(11'd0);
      send_word(1'b1, KW'(7));
      send_word(1'b0, KW'(8));
      write_modulus(11'd2047);
      send_word(1'b1, KW'(1023));
      send_word(1'b0, KW'(2047));
      write_modulus(11'd1024);
      send_word(1'b0, KW'(1023));
   endtask

   task automatic test_backpressure;
      drain();
      receiver_gaps = 1'b0;
      hold_off = 300;
      for (int i = 0; i < 8; i++) send_word(1'($urandom_range(0, 1)), pick_key());
      receiver_gaps = 1'b1;
      drain();
   endtask

   task automatic test_random(input int n, input logic [qph_pkg::MOD_WIDTH-1:0] m);
      write_modulus(m);
      for (int i = 0; i < n; i++) send_word(1'($urandom_range(0, 1)), pick_key());
   endtask

   initial begin
      shadow_modulus = qph_pkg::MOD_RESET;
      shadow_count = 0;
      for (int i = 0; i < SLOTS; i++) begin
         shadow_used[i] = 1'b0;
         shadow_key[i] = '0;
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_probe_limit(11'd7, 9);
      test_probe_limit(11'd3, 2);
      test_modulus_extremes();
      test_backpressure();
      test_random(200, 11'd1021);
      test_random(150, 11'd97);
      test_random(150, 11'd13);
      drain();
      sender_gaps = 1'b0;
      receiver_gaps = 1'b0;
      test_random(200, 11'd509);
      drain();
      repeat (200) @(posedge clock);
      $display("Covered %0d words, %0d results, moduli 0..2047 incl. probe limit,",
               item_count, result_count);
      $display("duplicate inserts, long receiver hold-off and gap-free traffic.");
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("[quadratic_probe_hash_set] OK");
      end else begin
         $display("[quadratic_probe_hash_set] ERROR");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
hdl/qph_pkg.sv
hdl/qph_datapath.sv
hdl/qph_ctrl.sv
hdl/quadratic_probe_hash_set.sv
sim/tb_quadratic_probe_hash_set.sv
